[sv/mcbf_pkg.sv]
// Shared constants, codes and types for the multi-channel byte FIFO.
// No dependencies; imported by mcbf_alu, multi_channel_byte_fifo and the testbench.
package mcbf_pkg;

    localparam int NUM_CHANNELS = 3;
    localparam int RX_DEPTH     = 256;
    localparam int TX_DEPTH     = 256;
    localparam int MAX_BLOCK    = 64;

    localparam int NQ     = 2 * NUM_CHANNELS;
    localparam int QW     = (NQ > 1) ? $clog2(NQ) : 1;
    localparam int MAXD   = (RX_DEPTH > TX_DEPTH) ? RX_DEPTH : TX_DEPTH;
    localparam int PW     = $clog2(MAXD);
    localparam int CW     = $clog2(MAXD + 1);
    localparam int LEN_W  = 7;
    localparam int XW     = (CW > LEN_W) ? CW : LEN_W;
    localparam int RX_AW  = $clog2(NUM_CHANNELS * RX_DEPTH);
    localparam int TX_AW  = $clog2(NUM_CHANNELS * TX_DEPTH);
    localparam int USED_W = 9;

    localparam logic [2:0] FN_PUSH   = 3'd0;
    localparam logic [2:0] FN_POP    = 3'd1;
    localparam logic [2:0] FN_PEEK   = 3'd2;
    localparam logic [2:0] FN_RD_BLK = 3'd3;
    localparam logic [2:0] FN_WR_BLK = 3'd4;
    localparam logic [2:0] FN_STATUS = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_BLK_RD,
        ST_BLK_WAIT
    } state_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_SUB
    } cnt_op_t;

    typedef struct packed {
        cnt_op_t            op;
        logic               dir;
        logic [LEN_W-1:0]   len;
    } alu_ctl_t;

    typedef struct packed {
        logic [CW-1:0]      cnt_after;
        logic [PW-1:0]      ptr_next;
        logic [USED_W-1:0]  used;
        logic [USED_W-1:0]  space;
        logic               is_empty;
        logic               is_full;
    } alu_res_t;

endpackage

[sv/multi_channel_byte_fifo.sv]
// Multi-channel byte FIFO: NUM_CHANNELS channels x {receive, transmit} queues.
// Push, block-write byte, status, empty block read, refusals: result registered at the
// accept edge, one item per cycle while the output is not stalled. Pop and peek: the
// byte passes the store read register, then the output register. Block read of L bytes:
// one store read then one result per byte. Reset clears pointers, counts, burst state and
// the output valid flag; byte stores are not cleared (only written entries are ever read).
// Depends on mcbf_pkg, mcbf_alu and mcbf_ram.
module multi_channel_byte_fifo import mcbf_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    // input word channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        func,
    input  logic [1:0]        channel,
    input  logic              direction,
    input  logic [7:0]        byte_in,
    input  logic [LEN_W-1:0]  block_length,
    input  logic              block_first,
    // result word channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        byte_out,
    output logic              ok,
    output logic              last,
    output logic [USED_W-1:0] used,
    output logic [USED_W-1:0] space,
    output logic              is_empty,
    output logic              is_full
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [PW-1:0] head_reg [NQ];
    logic [PW-1:0] head_next [NQ];
    logic [PW-1:0] tail_reg [NQ];
    logic [PW-1:0] tail_next [NQ];
    logic [CW-1:0] cnt_reg [NQ];
    logic [CW-1:0] cnt_next [NQ];

    // block-write burst tracking
    logic [LEN_W-1:0] burst_rem_reg, burst_rem_next;
    logic             burst_acc_reg, burst_acc_next;
    logic [QW-1:0]    burst_q_reg, burst_q_next;

    // latched item for multi-cycle operations
    logic [QW-1:0]    q_reg, q_next;
    logic [1:0]       ch_reg, ch_next;
    logic             dir_reg, dir_next;
    logic [LEN_W-1:0] left_reg, left_next;

    // output register (parts the two handshakes)
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        byte_out_reg, byte_out_next;
    logic              ok_reg, ok_next;
    logic              last_reg, last_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic [USED_W-1:0] space_reg, space_next;
    logic              empty_reg, empty_next;
    logic              full_reg, full_next;

    // ------------------------------------------------------------------
    // Item decode and queue selection
    // ------------------------------------------------------------------
    logic          out_free;
    logic          acc;
    logic          ch_ok;
    logic [QW-1:0] q_in;
    logic [QW-1:0] q_sel;
    logic [1:0]    ch_sel;
    logic          dir_sel;
    logic          use_tail;
    logic [PW-1:0] ptr_sel;
    logic [CW-1:0] cnt_sel;
    logic [CW-1:0] free_cnt;
    logic          empty_now;
    logic          full_now;
    logic          len_over;
    logic          len_gt_cnt;
    logic          len_gt_free;
    logic          burst_ok;

    alu_ctl_t      alu_ctl;
    alu_res_t      alu_res;

    // decoded actions
    cnt_op_t op;
    logic    wr_en;
    logic    rd_en;
    logic    adv_head;
    logic    adv_tail;
    logic    imm_ok;
    logic    go_rd;
    logic    go_blk;
    logic    burst_cancel;
    logic    burst_start;
    logic    burst_step;
    logic    ld_imm;

    // store ports
    logic [RX_AW-1:0] rx_waddr, rx_raddr;
    logic [TX_AW-1:0] tx_waddr, tx_raddr;
    logic [7:0]       rx_rdata, tx_rdata;
    logic [7:0]       rd_byte;

    // output slot can take a word at this edge
    assign out_free = !out_valid_reg || !out_stall;
    assign acc      = (state_reg == ST_IDLE) && in_valid && out_free;

    assign ch_ok = (int'(channel) < NUM_CHANNELS);
    // bad channels map to queue 0; their results are forced to zero, apart from last, anyway
    assign q_in  = !ch_ok ? '0 :
                   direction ? (QW'(NUM_CHANNELS) + QW'(channel)) : QW'(channel);

    assign q_sel   = (state_reg == ST_IDLE) ? q_in : q_reg;
    assign ch_sel  = (state_reg == ST_IDLE) ? channel : ch_reg;
    assign dir_sel = (state_reg == ST_IDLE) ? direction : dir_reg;

    assign use_tail = (state_reg == ST_IDLE) && (func == FN_PUSH || func == FN_WR_BLK);
    assign ptr_sel  = use_tail ? tail_reg[q_sel] : head_reg[q_sel];
    assign cnt_sel  = cnt_reg[q_sel];

    assign alu_ctl.op  = op;
    assign alu_ctl.dir = dir_sel;
    assign alu_ctl.len = block_length;

    mcbf_alu u_alu (
        .ctl      (alu_ctl),
        .cnt      (cnt_sel),
        .ptr      (ptr_sel),
        .free_cnt (free_cnt),
        .res      (alu_res)
    );

    assign empty_now   = (cnt_sel == '0);
    assign full_now    = (free_cnt == '0);
    assign len_over    = (int'(block_length) > MAX_BLOCK);
    assign len_gt_cnt  = (XW'(block_length) > XW'(cnt_sel));
    assign len_gt_free = (XW'(block_length) > XW'(free_cnt));
    // continuation byte of an open burst on the same queue
    assign burst_ok    = burst_acc_reg && (burst_q_reg == q_in) &&
                         (burst_rem_reg != '0) && (free_cnt != '0);

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (go_rd)
                begin
                    state_next = ST_RD_WAIT;
                end
                else if (go_blk)
                begin
                    state_next = ST_BLK_RD;
                end
            end
            ST_RD_WAIT:
            begin
                state_next = ST_IDLE;
            end
            ST_BLK_RD:
            begin
                if (out_free)
                begin
                    state_next = ST_BLK_WAIT;
                end
            end
            ST_BLK_WAIT:
            begin
                state_next = (left_reg == LEN_W'(1)) ? ST_IDLE : ST_BLK_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs (actions for this cycle)
    // ------------------------------------------------------------------
    always_comb
    begin
        op           = CNT_HOLD;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        adv_head     = 1'b0;
        adv_tail     = 1'b0;
        imm_ok       = 1'b0;
        go_rd        = 1'b0;
        go_blk       = 1'b0;
        burst_cancel = 1'b0;
        burst_start  = 1'b0;
        burst_step   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    if (!ch_ok || func != FN_WR_BLK)
                    begin
                        burst_cancel = 1'b1;
                    end
                    if (ch_ok)
                    begin
                        case (func)
                            FN_PUSH:
                            begin
                                if (!full_now)
                                begin
                                    wr_en    = 1'b1;
                                    adv_tail = 1'b1;
                                    op       = CNT_INC;
                                    imm_ok   = 1'b1;
                                end
                            end
                            FN_POP:
                            begin
                                if (!empty_now)
                                begin
                                    rd_en    = 1'b1;
                                    adv_head = 1'b1;
                                    op       = CNT_DEC;
                                    go_rd    = 1'b1;
                                end
                            end
                            FN_PEEK:
                            begin
                                if (!empty_now)
                                begin
                                    rd_en = 1'b1;
                                    go_rd = 1'b1;
                                end
                            end
                            FN_RD_BLK:
                            begin
                                // all-or-nothing; zero length succeeds with no data
                                if (!len_over && !len_gt_cnt)
                                begin
                                    imm_ok = 1'b1;
                                    if (block_length != '0)
                                    begin
                                        op     = CNT_SUB;
                                        go_blk = 1'b1;
                                    end
                                end
                            end
                            FN_WR_BLK:
                            begin
                                if (block_first)
                                begin
                                    burst_cancel = 1'b1;
                                    if (!len_over && !len_gt_free)
                                    begin
                                        imm_ok = 1'b1;
                                        if (block_length != '0)
                                        begin
                                            wr_en       = 1'b1;
                                            adv_tail    = 1'b1;
                                            op          = CNT_INC;
                                            burst_start = 1'b1;
                                        end
                                    end
                                end
                                else if (burst_ok)
                                begin
                                    wr_en      = 1'b1;
                                    adv_tail   = 1'b1;
                                    op         = CNT_INC;
                                    burst_step = 1'b1;
                                    imm_ok     = 1'b1;
                                end
                                else
                                begin
                                    burst_cancel = 1'b1;
                                end
                            end
                            FN_STATUS:
                            begin
                                imm_ok = 1'b1;
                            end
                            default:
                            begin
                                imm_ok = 1'b0;
                            end
                        endcase
                    end
                end
            end
            ST_BLK_RD:
            begin
                // next block byte is fetched only when its result can be stored
                if (out_free)
                begin
                    rd_en    = 1'b1;
                    adv_head = 1'b1;
                end
            end
            default:
            begin
                op = CNT_HOLD;
            end
        endcase
    end

    assign ld_imm   = acc && !go_rd && !go_blk;
    assign in_stall = !((state_reg == ST_IDLE) && out_free);

    // ------------------------------------------------------------------
    // Byte stores
    // ------------------------------------------------------------------
    assign rx_waddr = RX_AW'(ch_sel) * RX_AW'(RX_DEPTH) + RX_AW'(tail_reg[q_sel]);
    assign rx_raddr = RX_AW'(ch_sel) * RX_AW'(RX_DEPTH) + RX_AW'(head_reg[q_sel]);
    assign tx_waddr = TX_AW'(ch_sel) * TX_AW'(TX_DEPTH) + TX_AW'(tail_reg[q_sel]);
    assign tx_raddr = TX_AW'(ch_sel) * TX_AW'(TX_DEPTH) + TX_AW'(head_reg[q_sel]);

    mcbf_ram #(
        .WIDTH (8),
        .DEPTH (NUM_CHANNELS * RX_DEPTH)
    ) u_rx_store (
        .clk   (clk),
        .we    (wr_en && !dir_sel),
        .waddr (rx_waddr),
        .wdata (byte_in),
        .re    (rd_en && !dir_sel),
        .raddr (rx_raddr),
        .rdata (rx_rdata)
    );

    mcbf_ram #(
        .WIDTH (8),
        .DEPTH (NUM_CHANNELS * TX_DEPTH)
    ) u_tx_store (
        .clk   (clk),
        .we    (wr_en && dir_sel),
        .waddr (tx_waddr),
        .wdata (byte_in),
        .re    (rd_en && dir_sel),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

    assign rd_byte = dir_reg ? tx_rdata : rx_rdata;

    // ------------------------------------------------------------------
    // Next values: queue pointers, counts, burst, latched item
    // ------------------------------------------------------------------
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (adv_head)
        begin
            head_next[q_sel] = alu_res.ptr_next;
        end
        if (adv_tail)
        begin
            tail_next[q_sel] = alu_res.ptr_next;
        end
        if (op != CNT_HOLD)
        begin
            cnt_next[q_sel] = alu_res.cnt_after;
        end

        burst_rem_next = burst_rem_reg;
        burst_acc_next = burst_acc_reg;
        burst_q_next   = burst_q_reg;
        if (burst_cancel)
        begin
            burst_rem_next = '0;
            burst_acc_next = 1'b0;
        end
        if (burst_start)
        begin
            burst_rem_next = block_length - LEN_W'(1);
            burst_acc_next = (block_length != LEN_W'(1));
            burst_q_next   = q_in;
        end
        else if (burst_step)
        begin
            burst_rem_next = burst_rem_reg - LEN_W'(1);
            burst_acc_next = (burst_rem_reg != LEN_W'(1));
        end

        q_next    = q_reg;
        ch_next   = ch_reg;
        dir_next  = dir_reg;
        left_next = left_reg;
        if (acc)
        begin
            q_next    = q_in;
            ch_next   = channel;
            dir_next  = direction;
            left_next = block_length;
        end
        else if (state_reg == ST_BLK_WAIT)
        begin
            left_next = left_reg - LEN_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Next values: output register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        byte_out_next  = byte_out_reg;
        ok_next        = ok_reg;
        last_next      = last_reg;
        used_next      = used_reg;
        space_next     = space_reg;
        empty_next     = empty_reg;
        full_next      = full_reg;

        if (ld_imm)
        begin
            out_valid_next = 1'b1;
            byte_out_next  = '0;
            ok_next        = imm_ok;
            last_next      = 1'b1;
            used_next      = ch_ok ? alu_res.used : '0;
            space_next     = ch_ok ? alu_res.space : '0;
            empty_next     = ch_ok && alu_res.is_empty;
            full_next      = ch_ok && alu_res.is_full;
        end
        else if (state_reg == ST_RD_WAIT || state_reg == ST_BLK_WAIT)
        begin
            // counts were updated at the accept edge: they already reflect the
            // whole item, as every byte of a block read reports
            out_valid_next = 1'b1;
            byte_out_next  = rd_byte;
            ok_next        = 1'b1;
            last_next      = (state_reg == ST_RD_WAIT) || (left_reg == LEN_W'(1));
            used_next      = alu_res.used;
            space_next     = alu_res.space;
            empty_next     = alu_res.is_empty;
            full_next      = alu_res.is_full;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < NQ; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            burst_rem_reg <= '0;
            burst_acc_reg <= 1'b0;
            burst_q_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            burst_rem_reg <= burst_rem_next;
            burst_acc_reg <= burst_acc_next;
            burst_q_reg   <= burst_q_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        ch_reg       <= ch_next;
        dir_reg      <= dir_next;
        left_reg     <= left_next;
        byte_out_reg <= byte_out_next;
        ok_reg       <= ok_next;
        last_reg     <= last_next;
        used_reg     <= used_next;
        space_reg    <= space_next;
        empty_reg    <= empty_next;
        full_reg     <= full_next;
    end

    assign out_valid = out_valid_reg;
    assign byte_out  = byte_out_reg;
    assign ok        = ok_reg;
    assign last      = last_reg;
    assign used      = used_reg;
    assign space     = space_reg;
    assign is_empty  = empty_reg;
    assign is_full   = full_reg;

endmodule

[sv/mcbf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the receive and transmit byte stores.
module mcbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/mcbf_alu.sv]
// Shared count/pointer unit: fill count update, wrapping pointer step, status.
// Depends on mcbf_pkg.
module mcbf_alu import mcbf_pkg::*; (
    input  alu_ctl_t       ctl,
    input  logic [CW-1:0]  cnt,
    input  logic [PW-1:0]  ptr,
    output logic [CW-1:0]  free_cnt,
    output alu_res_t       res
);

    logic [CW-1:0] depth;
    logic [CW-1:0] cnt_after;
    logic [PW:0]   ptr_inc;

    always_comb
    begin
        depth    = ctl.dir ? CW'(TX_DEPTH) : CW'(RX_DEPTH);
        free_cnt = depth - cnt;

        case (ctl.op)
            CNT_INC: cnt_after = cnt + CW'(1);
            CNT_DEC: cnt_after = cnt - CW'(1);
            CNT_SUB: cnt_after = cnt - CW'(ctl.len);
            default: cnt_after = cnt;
        endcase

        // pointer wraps at the depth of the selected direction
        ptr_inc = {1'b0, ptr} + (PW+1)'(1);

        res.cnt_after = cnt_after;
        res.ptr_next  = (ptr_inc == (PW+1)'(depth)) ? '0 : ptr_inc[PW-1:0];
        res.used      = USED_W'(cnt_after);
        res.space     = USED_W'(depth - cnt_after);
        res.is_empty  = (cnt_after == '0);
        res.is_full   = (cnt_after == depth);
    end

endmodule

[tb/testbench.sv]
// Self-checking bench for multi_channel_byte_fifo: directed corner words, a fill/drain
// pass and random burst-heavy traffic, checked against a built-in queue predictor.
// Depends on mcbf_pkg and the multi_channel_byte_fifo RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mcbf_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [2:0] FN_UNUSED_A = 3'd6;
    localparam logic [2:0] FN_UNUSED_B = 3'd7;
    localparam logic [1:0] CH_BAD      = 2'(NUM_CHANNELS);
    localparam logic       DIR_RX      = 1'b0;
    localparam logic       DIR_TX      = 1'b1;

    // One input word, in port order
    typedef struct packed {
        logic [2:0]       func;
        logic [1:0]       channel;
        logic             direction;
        logic [7:0]       byte_in;
        logic [LEN_W-1:0] block_length;
        logic             block_first;
    } fifo_word_t;

    // One result word
    typedef struct packed {
        logic [7:0]        byte_out;
        logic              ok;
        logic              last;
        logic [USED_W-1:0] used;
        logic [USED_W-1:0] space;
        logic              is_empty;
        logic              is_full;
    } fifo_result_t;

    // Ways a random block write burst can be spoiled
    typedef enum int {
        CLEAN,
        CUT_SHORT,
        EXTRA_BYTE,
        WRONG_QUEUE
    } burst_flaw_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic       in_stall;
    fifo_word_t in_word = '0;

    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [7:0]        byte_out;
    logic              ok;
    logic              last;
    logic [USED_W-1:0] used;
    logic [USED_W-1:0] space;
    logic              is_empty;
    logic              is_full;

    // Words waiting for the driver, results waiting for the monitor
    fifo_word_t   words_to_send [$];
    fifo_result_t due_results [$];
    fifo_result_t want;

    // Predictor state: one circular store per queue, queue index = dir*NUM_CHANNELS+ch
    logic [7:0] byte_mem [NQ][MAXD];
    int         head_ptr [NQ];
    int         tail_ptr [NQ];
    int         fill_level [NQ];
    int         burst_left;
    bit         burst_live;
    int         burst_q;

    // Handshake bookkeeping and idling knobs (percent of cycles)
    logic in_taken = 1'b0;
    int   send_gap_pct;
    int   stall_pct;

    int words_made;
    int words_in;
    int results_checked;
    int refusals;
    int full_hits;
    int fail_count;

    multi_channel_byte_fifo uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (in_word.func),
        .channel      (in_word.channel),
        .direction    (in_word.direction),
        .byte_in      (in_word.byte_in),
        .block_length (in_word.block_length),
        .block_first  (in_word.block_first),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_out     (byte_out),
        .ok           (ok),
        .last         (last),
        .used         (used),
        .space        (space),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------
    function automatic int q_depth(input int qi);
        return (qi >= NUM_CHANNELS) ? TX_DEPTH : RX_DEPTH;
    endfunction

    function automatic void put_byte(input int qi, input logic [7:0] b);
        byte_mem[qi][tail_ptr[qi]] = b;
        tail_ptr[qi] = (tail_ptr[qi] + 1 == q_depth(qi)) ? 0 : tail_ptr[qi] + 1;
        fill_level[qi]++;
    endfunction

    function automatic logic [7:0] take_byte(input int qi);
        logic [7:0] b;
        b = byte_mem[qi][head_ptr[qi]];
        head_ptr[qi] = (head_ptr[qi] + 1 == q_depth(qi)) ? 0 : head_ptr[qi] + 1;
        fill_level[qi]--;
        return b;
    endfunction

    // Queue one result; counts are always those of the queue as it stands now
    function automatic void expect_word(input int qi, input logic [7:0] b,
                                        input logic okv, input logic lastv);
        fifo_result_t r;
        int           dep;
        dep = q_depth(qi);
        r.byte_out = b;
        r.ok       = okv;
        r.last     = lastv;
        r.used     = USED_W'(fill_level[qi]);
        r.space    = USED_W'(dep - fill_level[qi]);
        r.is_empty = (fill_level[qi] == 0);
        r.is_full  = (fill_level[qi] >= dep);
        due_results.push_back(r);
    endfunction

    // Apply one accepted word to the queues and queue what it must produce
    task automatic apply_to_queues(input fifo_word_t w);
        int           qi;
        int           dep;
        int           room;
        int           k;
        logic [7:0]   grab [MAX_BLOCK];
        fifo_result_t r;
        if (w.channel >= NUM_CHANNELS) begin
            // bad channel: all-zero result with last set, burst dropped
            burst_left = 0;
            burst_live = 0;
            r = '0;
            r.last = 1'b1;
            due_results.push_back(r);
            return;
        end
        qi   = w.direction * NUM_CHANNELS + w.channel;
        dep  = q_depth(qi);
        room = dep - fill_level[qi];
        if (w.func != FN_WR_BLK) begin
            burst_left = 0;
            burst_live = 0;
        end
        case (w.func)
            FN_PUSH:
                if (fill_level[qi] >= dep)
                    expect_word(qi, 8'h00, 1'b0, 1'b1);
                else
                begin
                    put_byte(qi, w.byte_in);
                    expect_word(qi, 8'h00, 1'b1, 1'b1);
                end
            FN_POP:
                if (fill_level[qi] == 0)
                    expect_word(qi, 8'h00, 1'b0, 1'b1);
                else
                    expect_word(qi, take_byte(qi), 1'b1, 1'b1);
            FN_PEEK:
                if (fill_level[qi] == 0)
                    expect_word(qi, 8'h00, 1'b0, 1'b1);
                else
                    expect_word(qi, byte_mem[qi][head_ptr[qi]], 1'b1, 1'b1);
            FN_RD_BLK:
                if (w.block_length > MAX_BLOCK || w.block_length > fill_level[qi])
                    expect_word(qi, 8'h00, 1'b0, 1'b1);
                else if (w.block_length == 0)
                    expect_word(qi, 8'h00, 1'b1, 1'b1);
                else
                begin
                    // all bytes leave first: every result carries the final counts
                    for (k = 0; k < w.block_length; k++)
                        grab[k] = take_byte(qi);
                    for (k = 0; k < w.block_length; k++)
                        expect_word(qi, grab[k], 1'b1, k == w.block_length - 1);
                end
            FN_WR_BLK:
                if (w.block_first) begin
                    burst_left = 0;
                    burst_live = 0;
                    if (w.block_length > MAX_BLOCK || w.block_length > room)
                        expect_word(qi, 8'h00, 1'b0, 1'b1);
                    else
                    begin
                        if (w.block_length > 0) begin
                            put_byte(qi, w.byte_in);
                            burst_left = w.block_length - 1;
                            burst_live = (burst_left > 0);
                            burst_q    = qi;
                        end
                        expect_word(qi, 8'h00, 1'b1, 1'b1);
                    end
                end
                else if (burst_live && burst_q == qi && burst_left > 0 && room > 0) begin
                    put_byte(qi, w.byte_in);
                    burst_left--;
                    burst_live = (burst_left > 0);
                    expect_word(qi, 8'h00, 1'b1, 1'b1);
                end
                else
                begin
                    // stray byte: refused, burst dropped
                    burst_left = 0;
                    burst_live = 0;
                    expect_word(qi, 8'h00, 1'b0, 1'b1);
                end
            FN_STATUS:
                expect_word(qi, 8'h00, 1'b1, 1'b1);
            default:
                // unused codes answer like status but refused
                expect_word(qi, 8'h00, 1'b0, 1'b1);
        endcase
    endtask

    //------------------------------------------------------------------
    // Checking
    //------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("MISMATCH at %0t ns: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [8:0] got,
                               input logic [8:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("result %0d %s = %0h, expected %0h",
                                      results_checked, name, got, exp_val));
    endtask

    // Monitor: results first, then the input handshake of the same edge
    always @(posedge clk) begin
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && out_valid && !out_stall) begin
            if (due_results.size() == 0)
                report_mismatch("result word with nothing expected");
            else
            begin
                want = due_results.pop_front();
                check_field("byte_out", 9'(byte_out), 9'(want.byte_out));
                check_field("ok",       9'(ok),       9'(want.ok));
                check_field("last",     9'(last),     9'(want.last));
                check_field("used",     used,         want.used);
                check_field("space",    space,        want.space);
                check_field("is_empty", 9'(is_empty), 9'(want.is_empty));
                check_field("is_full",  9'(is_full),  9'(want.is_full));
                if (!want.ok)
                    refusals++;
                if (want.is_full)
                    full_hits++;
            end
            results_checked++;
        end
        if (rst_n && in_valid && !in_stall) begin
            apply_to_queues(in_word);
            words_in++;
        end
    end

    //------------------------------------------------------------------
    // Driver: new word at the falling edge once the previous one is taken;
    // a held word never changes while it waits
    //------------------------------------------------------------------
    always @(negedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (!in_valid || in_taken) begin
                if (words_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    in_word  <= words_to_send.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------
    task automatic send_word(input logic [2:0] f, input logic [1:0] ch, input logic dir,
                             input logic [7:0] b, input logic [LEN_W-1:0] len,
                             input logic first);
        fifo_word_t w;
        w.func         = f;
        w.channel      = ch;
        w.direction    = dir;
        w.byte_in      = b;
        w.block_length = len;
        w.block_first  = first;
        words_to_send.push_back(w);
        words_made++;
    endtask

    // Block write: leading word with the length, then the follow-on bytes.
    // Oversized bursts get at most two (stray) followers.
    task automatic write_burst(input logic [1:0] ch, input logic dir, input int len,
                               input burst_flaw_t flaw);
        int         followers;
        int         bad_at;
        int         k;
        logic [2:0] f;
        followers = (len > MAX_BLOCK) ? $urandom_range(2) : ((len > 0) ? len - 1 : 0);
        bad_at    = (followers > 0) ? $urandom_range(followers - 1) : 0;
        send_word(FN_WR_BLK, ch, dir, 8'($urandom), LEN_W'(len), 1'b1);
        for (k = 0; k < followers; k++) begin
            if (k == bad_at && flaw == CUT_SHORT) begin
                // another function mid-burst; the rest become stray bytes
                f = 3'($urandom_range(FN_STATUS));
                if (f == FN_WR_BLK)
                    f = FN_STATUS;
                send_word(f, ch, dir, 8'($urandom), LEN_W'($urandom_range(4)), 1'b0);
            end
            if (k == bad_at && flaw == WRONG_QUEUE)
                send_word(FN_WR_BLK, ch, ~dir, 8'($urandom), LEN_W'($urandom), 1'b0);
            else
                send_word(FN_WR_BLK, ch, dir, 8'($urandom), LEN_W'($urandom), 1'b0);
        end
        if (flaw == EXTRA_BYTE)
            send_word(FN_WR_BLK, ch, dir, 8'($urandom), LEN_W'($urandom), 1'b0);
    endtask

    // Random traffic, mostly aimed at one hot queue that swings between filling
    // and draining. Shaping reads the predictor, which may lag a few words.
    task automatic run_phase(input int gap, input int stall, input int n_words);
        int          stop_at;
        int          hq;
        int          qi;
        int          pick;
        int          wr_w;
        int          n;
        int          lim;
        logic [1:0]  hot_ch;
        logic        hot_dir;
        logic [1:0]  ch;
        logic        dir;
        bit          filling;
        burst_flaw_t flaw;
        send_gap_pct = gap;
        stall_pct    = stall;
        stop_at      = words_made + n_words;
        hot_ch       = 2'($urandom_range(NUM_CHANNELS - 1));
        hot_dir      = 1'($urandom_range(1));
        hq           = hot_dir * NUM_CHANNELS + hot_ch;
        filling      = 1'b1;
        while (words_made < stop_at) begin
            while (words_to_send.size() >= 4)
                @(posedge clk);
            if (fill_level[hq] >= q_depth(hq) - 8)
                filling = 1'b0;
            else if (fill_level[hq] <= 4)
                filling = 1'b1;
            if ($urandom_range(3) != 0) begin
                ch  = hot_ch;
                dir = hot_dir;
            end
            else
            begin
                ch  = 2'($urandom_range(NUM_CHANNELS - 1));
                dir = 1'($urandom_range(1));
            end
            qi   = dir * NUM_CHANNELS + ch;
            wr_w = filling ? 55 : 25;
            pick = $urandom_range(99);
            if (pick < 6)
                // raw noise over every field bit
                send_word(3'($urandom), 2'($urandom), 1'($urandom), 8'($urandom),
                          LEN_W'($urandom), 1'($urandom));
            else if (pick < 8)
                send_word(FN_STATUS, ch, dir, 8'($urandom), LEN_W'($urandom), 1'($urandom));
            else if (pick < 10)
                send_word($urandom_range(1) ? FN_UNUSED_A : FN_UNUSED_B, ch, dir,
                          8'($urandom), LEN_W'($urandom), 1'($urandom));
            else if (pick < 12)
                send_word(3'($urandom), CH_BAD, dir, 8'($urandom), LEN_W'($urandom),
                          1'($urandom));
            else if (pick < 12 + wr_w) begin
                if ($urandom_range(1))
                    send_word(FN_PUSH, ch, dir, 8'($urandom), LEN_W'($urandom),
                              1'($urandom));
                else
                begin
                    if ($urandom_range(15) == 0)
                        n = $urandom_range(MAX_BLOCK + 1, 127);
                    else if ($urandom_range(7) == 0)
                        n = $urandom_range(MAX_BLOCK);
                    else
                        n = $urandom_range(1, 12);
                    flaw = ($urandom_range(4) == 0) ? burst_flaw_t'($urandom_range(1, 3))
                                                    : CLEAN;
                    write_burst(ch, dir, n, flaw);
                end
            end
            else
            begin
                pick = $urandom_range(99);
                lim  = (fill_level[qi] < MAX_BLOCK) ? fill_level[qi] : MAX_BLOCK;
                if (pick < 40)
                    send_word(FN_POP, ch, dir, 8'($urandom), LEN_W'($urandom), 1'($urandom));
                else if (pick < 55)
                    send_word(FN_PEEK, ch, dir, 8'($urandom), LEN_W'($urandom),
                              1'($urandom));
                else
                begin
                    n = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(lim);
                    send_word(FN_RD_BLK, ch, dir, 8'($urandom), LEN_W'(n), 1'($urandom));
                end
            end
        end
    endtask

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------
    initial begin : stimulus
        int k;
        int waited;
        send_gap_pct = 0;
        stall_pct    = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed corners, light idling on both sides
        send_gap_pct = 6;
        stall_pct    = 6;
        send_word(FN_POP,    0, DIR_RX, 8'h00, 0,   0);   // pop on empty
        send_word(FN_PEEK,   2, DIR_TX, 8'hFF, 127, 1);   // peek on empty
        send_word(FN_RD_BLK, 0, DIR_RX, 8'h00, 0,   0);   // zero-length read succeeds
        send_word(FN_RD_BLK, 0, DIR_RX, 8'h00, 1,   0);   // longer than fill
        send_word(FN_PUSH,   0, DIR_RX, 8'h00, 0,   0);
        send_word(FN_PUSH,   0, DIR_RX, 8'hFF, 127, 1);
        send_word(FN_PEEK,   0, DIR_RX, 8'h00, 0,   0);
        send_word(FN_STATUS, 0, DIR_RX, 8'h00, 0,   0);
        send_word(FN_RD_BLK, 0, DIR_RX, 8'h00, 127, 0);   // over the block limit
        send_word(FN_RD_BLK, 0, DIR_RX, 8'h00, LEN_W'(MAX_BLOCK + 1), 0);
        send_word(FN_WR_BLK, 1, DIR_TX, 8'h33, 0,   1);   // empty burst succeeds
        send_word(FN_WR_BLK, 1, DIR_TX, 8'h33, 100, 1);   // burst over the limit
        send_word(FN_WR_BLK, 1, DIR_TX, 8'h44, 0,   0);   // byte with no burst
        send_word(FN_WR_BLK, 1, DIR_TX, 8'hA5, 4,   1);
        send_word(FN_WR_BLK, 1, DIR_TX, 8'h5A, 0,   0);
        send_word(FN_WR_BLK, 0, DIR_TX, 8'h66, 0,   0);   // wrong queue drops burst
        send_word(FN_WR_BLK, 1, DIR_TX, 8'h67, 0,   0);   // now stray
        send_word(FN_WR_BLK, 1, DIR_TX, 8'h11, 3,   1);
        send_word(FN_PUSH,   1, DIR_RX, 8'h22, 0,   0);   // other function cancels
        send_word(FN_WR_BLK, 1, DIR_TX, 8'h23, 0,   0);
        send_word(FN_WR_BLK, 2, DIR_RX, 8'h81, 2,   1);
        send_word(FN_STATUS, CH_BAD, DIR_RX, 8'hFF, 127, 1);  // bad channel cancels too
        send_word(FN_WR_BLK, 2, DIR_RX, 8'h82, 0,   0);
        send_word(FN_UNUSED_A, 0, DIR_RX, 8'h00, 0, 0);
        send_word(FN_UNUSED_B, 1, DIR_TX, 8'h00, 0, 0);
        send_word(FN_RD_BLK, 1, DIR_TX, 8'h00, 3,   0);   // whole queue as a block
        send_word(FN_POP,    0, DIR_RX, 8'h00, 0,   0);
        send_word(FN_POP,    0, DIR_RX, 8'h00, 0,   0);
        send_word(FN_WR_BLK, 2, DIR_TX, 8'h01, 2,   1);   // burst run to its end...
        send_word(FN_WR_BLK, 2, DIR_TX, 8'h02, 0,   0);
        send_word(FN_WR_BLK, 2, DIR_TX, 8'h03, 0,   0);   // ...then one byte too many

        // Fill one queue to the brim through its wrap point, poke it, drain it
        send_gap_pct = 0;
        stall_pct    = 46;
        for (k = 0; k < TX_DEPTH / MAX_BLOCK; k++)
            write_burst(0, DIR_TX, MAX_BLOCK, CLEAN);
        send_word(FN_PUSH,   0, DIR_TX, 8'h77, 0, 0);     // push when full
        send_word(FN_WR_BLK, 0, DIR_TX, 8'h78, 1, 1);     // burst longer than space
        send_word(FN_STATUS, 0, DIR_TX, 8'h00, 0, 0);
        send_word(FN_PEEK,   0, DIR_TX, 8'h00, 0, 0);
        for (k = 0; k < TX_DEPTH / MAX_BLOCK; k++)
            send_word(FN_RD_BLK, 0, DIR_TX, 8'h00, LEN_W'(MAX_BLOCK), 0);
        send_word(FN_POP,    0, DIR_TX, 8'h00, 0, 0);

        // Random traffic under each idling mix
        run_phase(0,  0,  50);
        run_phase(46, 0,  50);
        run_phase(0,  46, 50);
        run_phase(6,  6,  50);

        // Let everything drain, then watch a while for extra results
        while (words_to_send.size() != 0 || in_valid)
            @(posedge clk);
        waited = 0;
        while (due_results.size() != 0 && waited < 200000) begin
            @(posedge clk);
            waited++;
        end
        if (due_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_results.size()));
        repeat (2 * MAX_BLOCK + 8) @(posedge clk);

        $display("Run covered %0d words in and %0d results out over all six queues,",
                 words_in, results_checked);
        $display("including %0d refused operations and %0d results on a full queue.",
                 refusals, full_hits);
        if (fail_count == 0)
            $display("PASS multi_channel_byte_fifo");
        else
            $display("FAIL multi_channel_byte_fifo");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("Timed out with %0d results still due", due_results.size());
        $display("FAIL multi_channel_byte_fifo");
        $finish;
    end

endmodule

[filelist.f]
sv/mcbf_pkg.sv
sv/mcbf_ram.sv
sv/mcbf_alu.sv
sv/multi_channel_byte_fifo.sv
tb/testbench.sv
